### design/fat32_file_sector_walker_assert.svh
// Assertion macros shared by the sector walker RTL.
`ifndef FAT32_FILE_SECTOR_WALKER_ASSERT_SVH
`define FAT32_FILE_SECTOR_WALKER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define FSW_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fsw assertion failed");

// Next-cycle implication, checked out of reset.
`define FSW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fsw assertion failed");

`endif

### design/fsw_pkg.sv
// Types and constants for the FAT32 file sector walker.
package fsw_pkg;

    localparam logic [27:0] CLUSTER_MASK    = 28'hFFFFFFF;
    localparam int          SECTOR_BYTES    = 512;
    localparam int          FAT_ENTRY_BYTES = 4;

    typedef enum logic [1:0] {
        FUNC_REWIND  = 2'd0,
        FUNC_ADVANCE = 2'd1,
        FUNC_FAT     = 2'd2
    } t_func;

    typedef enum logic [2:0] {
        ST_DATA   = 3'd0,
        ST_FAT    = 3'd1,
        ST_NONE   = 3'd2,
        ST_EOF    = 3'd3,
        ST_CHAIN  = 3'd4,
        ST_UNEXP  = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        REG_START_CLUSTER = 3'd0,
        REG_FILE_LENGTH   = 3'd1,
        REG_SECT_PER_CLUS = 3'd2,
        REG_FAT_BASE      = 3'd3,
        REG_DATA_BASE     = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [1:0]  func;
        logic [9:0]  byte_count;
        logic [31:0] fat_word;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] sector_address;
        logic [8:0]  fat_byte_offset;
        logic [9:0]  granted_bytes;
        logic [31:0] position;
    } t_out_item;

    typedef struct packed {
        logic [27:0] start_cluster;
        logic [31:0] file_length;
        logic [7:0]  clus_sectors;
        logic [15:0] fat_base;
        logic [31:0] data_base;
    } t_cfg;

endpackage

### design/fat32_file_sector_walker.sv
// Top level of the FAT32 file sector walker.
//
// Tracks the read position of one open FAT32 file (512-byte sectors) and
// names the next sector to fetch. Three channels, all valid/ready:
//   in  : one item per transfer (rewind, advance by bytes, FAT word).
//   out : exactly one result per input item, in order.
//   cfg : register writes (index 0..4); ready is always high. Writes must be
//         made only while no item is in flight; the block does not enforce it.
// Pipeline: an input register holds the accepted item; the next-state and
// result logic (one 32x8 multiply feeding the data sector add) sits
// between it and the result register. Output valid rises once the item
// has passed the input register and the result register; throughput is
// one item per cycle while the receiver does not stall, bounded by the
// update of the position/cluster state.
// When the receiver stalls, the result register holds and the input
// register takes one more item, after which in-ready drops until the
// result is taken.
// Reset (synchronous, active low) empties both registers and restores
// the registers and walk state to their defaults: cluster 2, position 0.
module fat32_file_sector_walker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  fsw_pkg::t_in_item   i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output fsw_pkg::t_out_item  o_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    import fsw_pkg::*;
    `include "fat32_file_sector_walker_assert.svh"

    t_in_item r_s1;
    logic     r_s1_valid;
    logic     r_out_valid;
    logic     s1_go;
    t_cfg     cfg;

    // s1 moves forward whenever the result slot is empty or being drained
    assign s1_go       = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_s1_valid || s1_go;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s1 <= i_in;
        end
    end

    fsw_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    fsw_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (s1_go),
        .i_item   (r_s1),
        .i_cfg    (cfg),
        .o_result (o_out)
    );

    assign o_out_valid = r_out_valid;

    `FSW_ASSERT_NOW(a_stall_only_when_full, i_clk, i_rst_n,
        !o_in_ready, r_s1_valid && r_out_valid && !i_out_ready)

endmodule

### design/fsw_cfg.sv
// Configuration register file of the sector walker.
module fsw_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    output fsw_pkg::t_cfg       o_cfg
);
    import fsw_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_cluster <= 28'd2;
            r_cfg.file_length   <= 32'd0;
            r_cfg.clus_sectors  <= 8'd1;
            r_cfg.fat_base      <= 16'd0;
            r_cfg.data_base     <= 32'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_START_CLUSTER: r_cfg.start_cluster <= i_cfg_data[27:0];
                REG_FILE_LENGTH:   r_cfg.file_length   <= i_cfg_data;
                REG_SECT_PER_CLUS: r_cfg.clus_sectors  <= i_cfg_data[7:0];
                REG_FAT_BASE:      r_cfg.fat_base      <= i_cfg_data[15:0];
                REG_DATA_BASE:     r_cfg.data_base     <= i_cfg_data;
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### design/fsw_step.sv
// Position state, per-item next-state logic and result register.
module fsw_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    input  fsw_pkg::t_in_item   i_item,
    input  fsw_pkg::t_cfg       i_cfg,
    output fsw_pkg::t_out_item  o_result
);
    import fsw_pkg::*;
    `include "fat32_file_sector_walker_assert.svh"

    logic [31:0] r_byte_position, n_byte_position;
    logic [27:0] r_cluster,       n_cluster;
    logic [7:0]  r_sic,           n_sic;
    logic        r_awaiting_fat,  n_awaiting_fat;
    t_out_item   r_result,        n_result;

    logic [27:0] mul_cluster;
    logic [7:0]  mul_sic;
    logic [31:0] rel_cluster;
    logic [31:0] rel_sectors;
    logic [31:0] data_addr;

    logic [9:0]  avail;
    logic [31:0] left;
    logic [9:0]  want_a;
    logic [9:0]  want;
    logic [31:0] new_pos;
    logic [7:0]  sic_inc;
    logic [27:0] next_cluster;

    // One shared multiplier for the data sector address.
    always_comb begin
        case (i_item.func)
            FUNC_REWIND: mul_cluster = i_cfg.start_cluster;
            FUNC_FAT:    mul_cluster = next_cluster;
            default:     mul_cluster = r_cluster;
        endcase
        mul_sic     = (i_item.func == FUNC_ADVANCE) ? sic_inc : 8'd0;
        rel_cluster = {4'd0, mul_cluster} - 32'd2;       // wraps for cluster < 2
        rel_sectors = rel_cluster * {24'd0, i_cfg.clus_sectors};
        data_addr   = i_cfg.data_base + rel_sectors + {24'd0, mul_sic};
    end

    // Advance clipping, next FAT cluster and sector-in-cluster increment
    always_comb begin
        next_cluster = i_item.fat_word[27:0] & CLUSTER_MASK;
        sic_inc      = r_sic + 8'd1;
        avail        = 10'(SECTOR_BYTES) - {1'b0, r_byte_position[8:0]};
        left         = i_cfg.file_length - r_byte_position;
        want_a       = (i_item.byte_count < avail) ? i_item.byte_count : avail;
        want         = ({22'd0, want_a} > left) ? left[9:0] : want_a;
        new_pos      = r_byte_position + {22'd0, want};
    end

    always_comb begin
        n_byte_position = r_byte_position;
        n_cluster       = r_cluster;
        n_sic           = r_sic;
        n_awaiting_fat  = r_awaiting_fat;

        n_result.status          = ST_UNEXP;
        n_result.sector_address  = 32'd0;
        n_result.fat_byte_offset = 9'd0;
        n_result.granted_bytes   = 10'd0;

        case (i_item.func)
            FUNC_REWIND: begin
                n_byte_position         = 32'd0;
                n_cluster               = i_cfg.start_cluster;
                n_sic                   = 8'd0;
                n_awaiting_fat          = 1'b0;
                n_result.status         = ST_DATA;
                n_result.sector_address = data_addr;
            end
            FUNC_ADVANCE: begin
                if (r_awaiting_fat) begin
                    n_result.status = ST_UNEXP;
                end else if (r_byte_position >= i_cfg.file_length) begin
                    n_result.status = ST_EOF;
                end else begin
                    n_byte_position        = new_pos;
                    n_result.granted_bytes = want;
                    n_result.status        = ST_NONE;
                    // crossed into a new sector still inside the file
                    if (want != 10'd0 && new_pos[8:0] == 9'd0
                            && new_pos < i_cfg.file_length) begin
                        n_sic = sic_inc;
                        if (sic_inc >= i_cfg.clus_sectors) begin
                            n_awaiting_fat           = 1'b1;
                            n_result.status          = ST_FAT;
                            n_result.sector_address  = {16'd0, i_cfg.fat_base}
                                                     + {11'd0, r_cluster[27:7]};
                            n_result.fat_byte_offset = {r_cluster[6:0], 2'b00};
                        end else begin
                            n_result.status         = ST_DATA;
                            n_result.sector_address = data_addr;
                        end
                    end
                end
            end
            FUNC_FAT: begin
                if (!r_awaiting_fat) begin
                    n_result.status = ST_UNEXP;
                end else if (next_cluster < 28'd2) begin
                    n_result.status = ST_CHAIN;        // keep waiting
                end else begin
                    n_cluster               = next_cluster;
                    n_sic                   = 8'd0;
                    n_awaiting_fat          = 1'b0;
                    n_result.status         = ST_DATA;
                    n_result.sector_address = data_addr;
                end
            end
            default: n_result.status = ST_UNEXP;
        endcase

        n_result.position = n_byte_position;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_position <= 32'd0;
            r_cluster       <= 28'd2;
            r_sic           <= 8'd0;
            r_awaiting_fat  <= 1'b0;
        end else if (i_go) begin
            r_byte_position <= n_byte_position;
            r_cluster       <= n_cluster;
            r_sic           <= n_sic;
            r_awaiting_fat  <= n_awaiting_fat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

    `FSW_ASSERT_NEXT(a_fat_req_sets_wait, i_clk, i_rst_n,
        i_go && n_result.status == ST_FAT, r_awaiting_fat)
    `FSW_ASSERT_NEXT(a_adv_while_wait, i_clk, i_rst_n,
        i_go && r_awaiting_fat && i_item.func == FUNC_ADVANCE,
        r_result.status == ST_UNEXP && $stable(r_byte_position))
    `FSW_ASSERT_NEXT(a_grant_bound, i_clk, i_rst_n,
        i_go, r_result.granted_bytes <= 10'(SECTOR_BYTES)
              && r_result.position == r_byte_position)

endmodule
